// File: hdl/c3f_pkg.sv
package c3f_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam int PIXEL_W = 8;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 5;
  localparam int KROW_W  = 24;
  localparam int DIV_W   = 8;
  localparam int SIZE_W  = 10;

  // Register indexes, at byte address 4 * index.
  localparam logic [2:0] REG_KERNEL_ROW0 = 3'd0;
  localparam logic [2:0] REG_KERNEL_ROW1 = 3'd1;
  localparam logic [2:0] REG_KERNEL_ROW2 = 3'd2;
  localparam logic [2:0] REG_DIVISOR     = 3'd3;
  localparam logic [2:0] REG_WIDTH       = 3'd4;
  localparam logic [2:0] REG_HEIGHT      = 3'd5;

  localparam logic [KROW_W-1:0] KERNEL_RESET  = 24'h010101;
  localparam logic [DIV_W-1:0]  DIVISOR_RESET = 8'd9;
  localparam logic [SIZE_W-1:0] WIDTH_RESET   = 10'd512;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET  = 10'd512;

endpackage

// File: hdl/c3f_video_if.sv
interface c3f_video_if;
  import c3f_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

// File: hdl/c3f_filtered_if.sv
interface c3f_filtered_if;
  import c3f_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_out;
  logic               run_last;
  logic               frame_last;

  modport source (output valid, output pixel_out, output run_last, output frame_last,
                  input ready);
  modport sink (input valid, input pixel_out, input run_last, input frame_last,
                output ready);
endinterface

// File: hdl/conv3x3_image_filter.sv
// Streaming 3x3 convolution over an 8-bit grayscale frame fed in raster order, followed
// by one drain row of w_eff items whose pixels are ignored. The kernel is applied
// unflipped, neighbors outside the frame count as zero, and each result is the low 8
// bits of |sum| / divisor. The item at row r, column c yields the result for (r-1, c-1),
// and the last item of a row also yields (r-1, W-1); row 0 yields nothing. Items are
// taken one at a time: a new item is not accepted until every result of the last one
// has been emitted, and emitting can wait on the output side. Each result goes through
// the single shared multiply-accumulate unit, which walks the nine kernel taps one per
// cycle, and the restoring divider, which retires one quotient bit per cycle over
// the 19-bit magnitude. The two line buffers are single-port memories read when an
// item is accepted and written back the cycle after. Configure only while idle.
module conv3x3_image_filter #(
  parameter int MAX_WIDTH  = c3f_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = c3f_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  c3f_video_if.sink                    video,
  c3f_filtered_if.source               filtered,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [c3f_pkg::ADDR_W-1:0]   paddr,
  input  logic [c3f_pkg::DATA_W-1:0]   pwdata,
  output logic [c3f_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import c3f_pkg::*;

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int CW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_HEIGHT + 1);
  localparam int SUM_W  = 20;
  localparam int MAG_W  = 19;
  localparam int PROD_W = 17;
  localparam int DCNT_W = $clog2(MAG_W);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_ABS   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  // Configuration registers.
  logic [KROW_W-1:0] kernel [0:2];
  logic [DIV_W-1:0]  divisor;
  logic [SIZE_W-1:0] image_width;
  logic [SIZE_W-1:0] image_height;

  logic       cfg_write;
  logic [2:0] cfg_index;

  assign pready    = 1'b1;
  assign cfg_index = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel[0]    <= KERNEL_RESET;
      kernel[1]    <= KERNEL_RESET;
      kernel[2]    <= KERNEL_RESET;
      divisor      <= DIVISOR_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KERNEL_ROW0: kernel[0]    <= pwdata[KROW_W-1:0];
        REG_KERNEL_ROW1: kernel[1]    <= pwdata[KROW_W-1:0];
        REG_KERNEL_ROW2: kernel[2]    <= pwdata[KROW_W-1:0];
        REG_DIVISOR:     divisor      <= pwdata[DIV_W-1:0];
        REG_WIDTH:       image_width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:      image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_KERNEL_ROW0: prdata = DATA_W'(kernel[0]);
      REG_KERNEL_ROW1: prdata = DATA_W'(kernel[1]);
      REG_KERNEL_ROW2: prdata = DATA_W'(kernel[2]);
      REG_DIVISOR:     prdata = DATA_W'(divisor);
      REG_WIDTH:       prdata = DATA_W'(image_width);
      REG_HEIGHT:      prdata = DATA_W'(image_height);
      default:         prdata = '0;
    endcase
  end

  // Frame size in use, with zero taken as one and large values saturated.
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;
  logic [DIV_W-1:0] d_eff;

  always_comb begin
    if (image_width == '0) w_eff = CW'(1);
    else if (int'(image_width) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    if (image_height == '0) h_eff = RW'(1);
    else if (int'(image_height) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(image_height);
    d_eff = (divisor == '0) ? DIV_W'(1) : divisor;
  end

  logic [2:0]  state;
  logic [AW-1:0] column_count;
  logic [RW-1:0] row_count;

  // Position of the arriving item. A size change since the last item may end the row or
  // the frame at once.
  logic          col_wrap;
  logic [RW:0]   row_pre;
  logic [AW-1:0] c_cur;
  logic [RW-1:0] r_cur;
  logic [CW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic          in_fire;

  assign in_fire     = video.valid && video.ready;
  assign video.ready = (state == S_IDLE);

  always_comb begin
    col_wrap = CW'(column_count) >= w_eff;
    row_pre  = col_wrap ? (RW+1)'(row_count) + 1'b1 : (RW+1)'(row_count);
    c_cur    = col_wrap ? '0 : column_count;
    r_cur    = (row_pre > (RW+1)'(h_eff)) ? '0 : row_pre[RW-1:0];
    col_inc  = CW'(c_cur) + 1'b1;
    row_inc  = (RW+1)'(r_cur) + 1'b1;
  end

  // Line buffers and the read data for the item at work.
  logic [PIXEL_W-1:0] line_above     [0:MAX_WIDTH-1];
  logic [PIXEL_W-1:0] line_two_above [0:MAX_WIDTH-1];
  logic [PIXEL_W-1:0] rd_above;
  logic [PIXEL_W-1:0] rd_two_above;

  // Item context.
  logic [AW-1:0]      col_at;
  logic [PIXEL_W-1:0] pix;
  logic               need_a;
  logic               need_b;
  logic               frame_end;
  logic               c_ge1;
  logic               c_ge2;
  logic [2:0]         rowmask;
  logic               off;

  logic [PIXEL_W-1:0] window [0:8];

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_above     <= line_above[c_cur];
      rd_two_above <= line_two_above[c_cur];
    end
    if (state == S_SHIFT) begin
      line_two_above[col_at] <= rd_above;
      line_above[col_at]     <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_at    <= c_cur;
      pix       <= (r_cur < h_eff) ? video.pixel_in : '0;
      need_a    <= (r_cur != '0) && (c_cur != '0);
      need_b    <= (r_cur != '0) && (col_inc == w_eff);
      frame_end <= (r_cur == h_eff);
      c_ge1     <= (c_cur >= AW'(1));
      c_ge2     <= (c_cur >= AW'(2));
      rowmask   <= {r_cur < h_eff, 1'b1, r_cur >= RW'(2)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      if (col_inc >= w_eff) begin
        column_count <= '0;
        row_count    <= (row_inc > (RW+1)'(h_eff)) ? '0 : row_inc[RW-1:0];
      end else begin
        column_count <= col_inc[AW-1:0];
        row_count    <= r_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) window[i] <= '0;
    end else if (state == S_SHIFT) begin
      window[0] <= window[1];
      window[1] <= window[2];
      window[2] <= rd_two_above;
      window[3] <= window[4];
      window[4] <= window[5];
      window[5] <= rd_above;
      window[6] <= window[7];
      window[7] <= window[8];
      window[8] <= pix;
    end
  end

  // Multiply-accumulate over the nine taps, one per cycle. The second result of an item
  // uses the kernel shifted one column right onto the window.
  logic [1:0]               tap_m;
  logic [1:0]               tap_n;
  logic signed [SUM_W-1:0]  acc;
  logic [2:0]               colmask;
  logic                     tap_en;
  logic [3:0]               widx;
  logic [PIXEL_W-1:0]       win_val;
  logic signed [7:0]        coef;
  logic signed [PROD_W-1:0] prod;

  always_comb begin
    colmask = off ? {1'b0, 1'b1, c_ge1} : {1'b1, 1'b1, c_ge2};
    tap_en  = rowmask[tap_m] && colmask[tap_n] && ((3'(tap_n) + 3'(off)) < 3'd3);
    widx    = 4'(tap_m) * 4'd3 + 4'(tap_n) + 4'(off);
    win_val = tap_en ? window[widx] : '0;
    coef    = $signed(kernel[tap_m][{tap_n, 3'b000} +: 8]);
    prod    = $signed({1'b0, win_val}) * coef;
  end

  // Restoring divider, one quotient bit per cycle.
  logic [MAG_W-1:0]  dq;
  logic [DIV_W-1:0]  rem;
  logic [DCNT_W-1:0] dcnt;
  logic [DIV_W:0]    trial;
  logic              q_bit;
  logic [SUM_W-1:0]  neg_acc;

  always_comb begin
    trial   = {rem, dq[MAG_W-1]};
    q_bit   = trial >= {1'b0, d_eff};
    neg_acc = SUM_W'(-acc);
  end

  // Output register.
  logic               out_valid;
  logic [PIXEL_W-1:0] out_pixel;
  logic               out_run_last;
  logic               out_frame_last;
  logic               out_load;

  assign out_load            = (state == S_EMIT) && (!out_valid || filtered.ready);
  assign filtered.valid      = out_valid;
  assign filtered.pixel_out  = out_pixel;
  assign filtered.run_last   = out_run_last;
  assign filtered.frame_last = out_frame_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pixel      <= dq[PIXEL_W-1:0];
      out_run_last   <= off || !need_b;
      out_frame_last <= off && frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) state <= S_SHIFT;
        end
        S_SHIFT: begin
          tap_m <= '0;
          tap_n <= '0;
          acc   <= '0;
          if (need_a) begin
            off   <= 1'b0;
            state <= S_MAC;
          end else if (need_b) begin
            off   <= 1'b1;
            state <= S_MAC;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MAC: begin
          acc <= acc + SUM_W'(prod);
          if (tap_n == 2'd2) begin
            tap_n <= '0;
            tap_m <= tap_m + 1'b1;
          end else begin
            tap_n <= tap_n + 1'b1;
          end
          if (tap_m == 2'd2 && tap_n == 2'd2) state <= S_ABS;
        end
        S_ABS: begin
          dq    <= acc[SUM_W-1] ? neg_acc[MAG_W-1:0] : acc[MAG_W-1:0];
          rem   <= '0;
          dcnt  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem  <= q_bit ? DIV_W'(trial - {1'b0, d_eff}) : trial[DIV_W-1:0];
          dq   <= {dq[MAG_W-2:0], q_bit};
          dcnt <= dcnt + 1'b1;
          if (dcnt == DCNT_W'(MAG_W - 1)) state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            if (!off && need_b) begin
              off   <= 1'b1;
              tap_m <= '0;
              tap_n <= '0;
              acc   <= '0;
              state <= S_MAC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_shift: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> state == S_SHIFT)
    else $error("accepted item did not move to the window shift");

  a_mac_taps: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> tap_m != 2'd3 && tap_n != 2'd3)
    else $error("tap counter out of range");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < d_eff)
    else $error("divider remainder not below divisor");

  a_frame_last_run_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_frame_last |-> out_run_last)
    else $error("frame_last without run_last");

  a_second_only_at_row_end: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC && off |-> need_b)
    else $error("second result computed for an item that does not end a row");
`endif

endmodule

// File: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import c3f_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_START  = 6000;
  localparam int HOLD_CYCLES = 1000;
  localparam int SETTLE      = 80;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel;
    logic               run_last;
    logic               frame_last;
  } filtered_t;

  typedef enum {FILL_RANDOM, FILL_STRIPES} fill_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  c3f_video_if    video();
  c3f_filtered_if filtered();

  conv3x3_image_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .video    (video),
    .filtered (filtered),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Shadow of the configuration registers and of the filter's own state.
  logic [KROW_W-1:0]  kernel_cfg [3];
  logic [DIV_W-1:0]   divisor_cfg;
  logic [SIZE_W-1:0]  width_cfg;
  logic [SIZE_W-1:0]  height_cfg;
  logic [PIXEL_W-1:0] mem_above     [MAX_WIDTH_DEF];
  logic [PIXEL_W-1:0] mem_two_above [MAX_WIDTH_DEF];
  logic [PIXEL_W-1:0] nbhd [9];
  int unsigned col_count;
  int unsigned row_count;

  logic [PIXEL_W-1:0] pixels_to_send [$];
  filtered_t          expected_filtered [$];
  int pushed_count = 0;
  int accepted_count = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int errors = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned maxv);
    if (v == '0) return 1;
    return (v > maxv) ? maxv : int'(v);
  endfunction

  function automatic logic [PIXEL_W-1:0] weighted_tap(int off, logic [2:0] colmask,
                                                      logic [2:0] rowmask);
    int acc;
    int d;
    logic signed [7:0] coef;
    logic [31:0] quot;
    acc = 0;
    for (int m = 0; m < 3; m++) begin
      for (int n = 0; n < 3; n++) begin
        if (rowmask[m] && colmask[n] && n + off < 3) begin
          coef = kernel_cfg[m][8*n +: 8];
          acc += int'(nbhd[m*3 + n + off]) * int'(coef);
        end
      end
    end
    if (acc < 0) acc = -acc;
    d = (divisor_cfg == '0) ? 1 : int'(divisor_cfg);
    quot = acc / d;
    return quot[PIXEL_W-1:0];
  endfunction

  // Advances the shadow state by one item and queues the results it causes.
  function automatic void convolve_item(logic [PIXEL_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    logic [PIXEL_W-1:0] p;
    logic [2:0] rmask;
    filtered_t res [2];
    int cnt;
    w = eff_size(width_cfg, MAX_WIDTH_DEF);
    h = eff_size(height_cfg, MAX_HEIGHT_DEF);
    if (col_count >= w) begin
      col_count = 0;
      row_count++;
    end
    if (row_count > h) row_count = 0;
    c = col_count;
    r = row_count;
    p = (r < h) ? pix : '0;
    nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2]; nbhd[2] = mem_two_above[c];
    nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5]; nbhd[5] = mem_above[c];
    nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8]; nbhd[8] = p;
    mem_two_above[c] = mem_above[c];
    mem_above[c] = p;
    cnt = 0;
    if (r >= 1) begin
      rmask = {r < h, 1'b1, r >= 2};
      if (c >= 1) begin
        res[cnt] = '{weighted_tap(0, {2'b11, c >= 2}, rmask), 1'b0, 1'b0};
        cnt++;
      end
      if (c == w - 1) begin
        res[cnt] = '{weighted_tap(1, {2'b01, c >= 1}, rmask), 1'b0, r == h};
        cnt++;
      end
      if (cnt > 0) res[cnt-1].run_last = 1'b1;
    end
    for (int i = 0; i < cnt; i++) expected_filtered.push_back(res[i]);
    col_count = c + 1;
    if (col_count >= w) begin
      col_count = 0;
      row_count = r + 1;
      if (row_count > h) row_count = 0;
    end
  endfunction

  // Items still needed to close the frame in progress, drain row included.
  function automatic int unsigned items_to_frame_end();
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    w = eff_size(width_cfg, MAX_WIDTH_DEF);
    h = eff_size(height_cfg, MAX_HEIGHT_DEF);
    c = col_count;
    r = row_count;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r > h) r = 0;
    return (h - r + 1) * w - c;
  endfunction

  function automatic bit no_gap_stretch();
    return cycle_count >= 10000 && cycle_count < 16000;
  endfunction

  function automatic bit take_gap();
    return !no_gap_stretch() && ($urandom_range(99) < 21);
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_KERNEL_ROW0: kernel_cfg[0] = val[KROW_W-1:0];
      REG_KERNEL_ROW1: kernel_cfg[1] = val[KROW_W-1:0];
      REG_KERNEL_ROW2: kernel_cfg[2] = val[KROW_W-1:0];
      REG_DIVISOR:     divisor_cfg   = val[DIV_W-1:0];
      REG_WIDTH:       width_cfg     = val[SIZE_W-1:0];
      REG_HEIGHT:      height_cfg    = val[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic push_pixels(input int unsigned n, input fill_t fill);
    logic [PIXEL_W-1:0] p;
    for (int unsigned i = 0; i < n; i++) begin
      if (fill == FILL_STRIPES) begin
        p = (i % 4 < 2) ? 8'hFF : 8'h00;
      end else begin
        case ($urandom_range(7))
          0: p = 8'h00;
          1: p = 8'hFF;
          default: p = PIXEL_W'($urandom_range(0, 255));
        endcase
      end
      pixels_to_send.push_back(p);
    end
    pushed_count += n;
  endtask

  // An item without results may still be in flight when the queue empties,
  // so give the block its worst-case item time before touching registers.
  task automatic wait_idle();
    while (accepted_count != pushed_count || expected_filtered.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    apb_write(REG_WIDTH, ($urandom() & ~32'h3FF) | DATA_W'(w));
    apb_write(REG_HEIGHT, ($urandom() & ~32'h3FF) | DATA_W'(h));
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Long output stall while the source keeps offering pixels.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (cycle_count == HOLD_START) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      video.valid <= 1'b0;
    end else begin
      if (video.valid && video.ready) begin
        convolve_item(video.pixel_in);
        accepted_count++;
      end
      if (!video.valid || video.ready) begin
        if (pixels_to_send.size() != 0 && !take_gap()) begin
          video.valid    <= 1'b1;
          video.pixel_in <= pixels_to_send.pop_front();
        end else begin
          video.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    filtered_t want;
    if (rst) begin
      filtered.ready <= 1'b0;
    end else begin
      if (filtered.valid && filtered.ready) begin
        if (expected_filtered.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: pixel_out=%0h run_last=%0b frame_last=%0b",
                   $time, filtered.pixel_out, filtered.run_last, filtered.frame_last);
        end else begin
          want = expected_filtered.pop_front();
          if (filtered.pixel_out !== want.pixel) begin
            errors++;
            $display("%0t: pixel_out expected %0h actual %0h",
                     $time, want.pixel, filtered.pixel_out);
          end
          if (filtered.run_last !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %0b actual %0b",
                     $time, want.run_last, filtered.run_last);
          end
          if (filtered.frame_last !== want.frame_last) begin
            errors++;
            $display("%0t: frame_last expected %0b actual %0b",
                     $time, want.frame_last, filtered.frame_last);
          end
        end
      end
      filtered.ready <= (hold_left == 0) && !take_gap();
    end
  end

  initial begin : stimulus
    int unsigned random_items;
    int unsigned n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    video.valid = 1'b0;
    video.pixel_in = '0;
    filtered.ready = 1'b0;
    kernel_cfg[0] = KERNEL_RESET;
    kernel_cfg[1] = KERNEL_RESET;
    kernel_cfg[2] = KERNEL_RESET;
    divisor_cfg = DIVISOR_RESET;
    width_cfg = WIDTH_RESET;
    height_cfg = HEIGHT_RESET;
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      mem_above[i] = '0;
      mem_two_above[i] = '0;
    end
    for (int i = 0; i < 9; i++) nbhd[i] = '0;
    col_count = 0;
    row_count = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // A full-width frame first, so that every line-buffer entry gets written
    // before any later frame can look at it. The width asked for is oversized
    // and saturates.
    apb_write(REG_KERNEL_ROW0, 32'h0080_8080);
    apb_write(REG_KERNEL_ROW1, 32'h0080_8080);
    apb_write(REG_KERNEL_ROW2, 32'h0080_8080);
    apb_write(REG_DIVISOR, 32'd1);
    set_size(1023, 1);
    push_pixels(16, FILL_STRIPES);
    push_pixels(items_to_frame_end() - 16, FILL_RANDOM);
    wait_idle();

    // Zero width, zero height and zero divisor, with the largest coefficients.
    apb_write(REG_KERNEL_ROW0, 32'h007F_7F7F);
    apb_write(REG_KERNEL_ROW1, 32'h007F_7F7F);
    apb_write(REG_KERNEL_ROW2, 32'h007F_7F7F);
    apb_write(REG_DIVISOR, 32'd0);
    set_size(0, 0);
    push_pixels(items_to_frame_end(), FILL_STRIPES);
    wait_idle();

    // Largest divisor; the quotient still overflows 8 bits and must wrap.
    apb_write(REG_DIVISOR, 32'd255);
    set_size(3, 3);
    push_pixels(items_to_frame_end(), FILL_STRIPES);
    wait_idle();

    // Uneven kernel, then width and height cut while a frame is under way.
    apb_write(REG_KERNEL_ROW0, 32'h0003_0201);
    apb_write(REG_KERNEL_ROW1, 32'h0080_7FF6);
    apb_write(REG_KERNEL_ROW2, 32'h00FD_FEFF);
    apb_write(REG_DIVISOR, 32'd1);
    set_size(5, 4);
    push_pixels(7, FILL_RANDOM);
    wait_idle();
    set_size(2, 4);
    push_pixels(3, FILL_RANDOM);
    wait_idle();
    set_size(2, 1);
    push_pixels(items_to_frame_end(), FILL_RANDOM);
    wait_idle();

    // Oversized height saturates: one column, tallest frame.
    apb_write(REG_KERNEL_ROW0, $urandom());
    apb_write(REG_KERNEL_ROW2, $urandom());
    apb_write(REG_DIVISOR, 32'd3);
    set_size(1, 1023);
    push_pixels(items_to_frame_end(), FILL_RANDOM);
    wait_idle();

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(1) == 0)
          apb_write(REG_KERNEL_ROW0 + 3'(k), $urandom());
      end
      if ($urandom_range(1) == 0)
        apb_write(REG_DIVISOR, ($urandom() & ~32'hFF) |
                  (($urandom_range(3) == 0) ? $urandom_range(0, 255)
                                            : $urandom_range(1, 12)));
      set_size(($urandom_range(9) == 0) ? $urandom_range(17, 80) : $urandom_range(0, 16),
               $urandom_range(0, 10));
      n = items_to_frame_end();
      push_pixels(n, FILL_RANDOM);
      random_items += n;
      wait_idle();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: conv3x3_image_filter.f
hdl/c3f_pkg.sv
hdl/c3f_video_if.sv
hdl/c3f_filtered_if.sv
hdl/conv3x3_image_filter.sv
tb/testbench.sv
